[hw/rtl/voxel_ray_traversal_macros.svh]
// Assertion helpers for the checker of the voxel ray caster.
`ifndef VOXEL_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define VRT_AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define VRT_AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define VRT_AST_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/vrt_pkg.sv]
package vrt_pkg;

    localparam int DEF_CHUNK_LENGTH   = 16;
    localparam int DEF_CHUNK_WIDTH    = 16;
    localparam int DEF_CHUNK_HEIGHT   = 64;
    localparam int DEF_WORLD_CHUNKS_X = 4;
    localparam int DEF_WORLD_CHUNKS_Y = 4;

    localparam int VOX_W  = 6;
    localparam int VAL_W  = 8;
    localparam int ORG_W  = 24;
    localparam int DIR_W  = 16;
    localparam int DIST_W = 24;
    localparam int FRAC_W = 16;

    // step lengths and crossing distances, Q.16 with saturation at 2^40 - 1
    localparam int T_W = 41;
    localparam logic [T_W-1:0] T_SAT = {1'b0, {(T_W-1){1'b1}}};

    localparam int MULA_W = 17;
    localparam int MULP_W = MULA_W + T_W;

    localparam int DIVN_W = 41;
    localparam int DIVD_W = 24;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [2:0] SIDE_UNKNOWN = 3'd0;
    localparam logic [2:0] SIDE_FRONT   = 3'd1;
    localparam logic [2:0] SIDE_BACK    = 3'd2;
    localparam logic [2:0] SIDE_RIGHT   = 3'd3;
    localparam logic [2:0] SIDE_LEFT    = 3'd4;
    localparam logic [2:0] SIDE_TOP     = 3'd5;
    localparam logic [2:0] SIDE_BOTTOM  = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_CHK, ST_SQ_M, ST_SQ_A, ST_SQRT, ST_DIV_S,
        ST_DIV_W, ST_DSEL, ST_TI_M, ST_TI_A, ST_STEP, ST_PT_M, ST_PT_A, ST_FIN
    } t_state;

    typedef enum logic [1:0] {DOP_TMAX, DOP_DELTA} t_dop;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quot;
    } t_div_rsp;

endpackage

[hw/rtl/voxel_ray_traversal.sv]
// Voxel ray caster over a bounded occupancy world.
// Input channel (i_valid / o_ready) takes one request a time: i_cmd selects a
// voxel write (i_voxel_*, nonzero i_voxel_value means solid) or a ray cast
// (i_origin_*, i_dir_*, i_max_distance, all fixed point).
// A write gives no result; o_ready stays high.
// A cast gives one result on the output channel (o_valid / i_ready): hit flag,
// chunk and local block, hit point and face; all fields zero on a miss.
// Cast datapath: one shared multiplier, a shared 41-step divider and a
// 16-step square root. The start voxel is read and checked first; a solid
// start voxel then needs only the finish state that loads the result.
// Otherwise setup computes norm, reach and step lengths, each voxel step
// runs select, memory read and test, and a hit computes the point before the finish.
// One cast is in flight at a time; o_ready is low while it runs.
// After reset the occupancy memory is cleared one row a cycle, over all
// WORLD_CHUNKS_Y * CHUNK_WIDTH * CHUNK_HEIGHT rows (4096 by default) with
// o_ready low. A result waiting on a stalled receiver does not block writes
// or the start of the next cast; that cast only holds before delivering.
module voxel_ray_traversal import vrt_pkg::*; #(
    parameter int CHUNK_LENGTH   = DEF_CHUNK_LENGTH,
    parameter int CHUNK_WIDTH    = DEF_CHUNK_WIDTH,
    parameter int CHUNK_HEIGHT   = DEF_CHUNK_HEIGHT,
    parameter int WORLD_CHUNKS_X = DEF_WORLD_CHUNKS_X,
    parameter int WORLD_CHUNKS_Y = DEF_WORLD_CHUNKS_Y
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_cmd,
    input  logic [VOX_W-1:0]         i_voxel_x,
    input  logic [VOX_W-1:0]         i_voxel_y,
    input  logic [VOX_W-1:0]         i_voxel_z,
    input  logic [VAL_W-1:0]         i_voxel_value,
    input  logic signed [ORG_W-1:0]  i_origin_x,
    input  logic signed [ORG_W-1:0]  i_origin_y,
    input  logic signed [ORG_W-1:0]  i_origin_z,
    input  logic signed [DIR_W-1:0]  i_dir_x,
    input  logic signed [DIR_W-1:0]  i_dir_y,
    input  logic signed [DIR_W-1:0]  i_dir_z,
    input  logic [DIST_W-1:0]        i_max_distance,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_hit,
    output logic [1:0]               o_chunk_x,
    output logic [1:0]               o_chunk_y,
    output logic [3:0]               o_block_x,
    output logic [3:0]               o_block_y,
    output logic [5:0]               o_block_z,
    output logic signed [ORG_W-1:0]  o_point_x,
    output logic signed [ORG_W-1:0]  o_point_y,
    output logic signed [ORG_W-1:0]  o_point_z,
    output logic [2:0]               o_side
);

    localparam int WX   = WORLD_CHUNKS_X * CHUNK_LENGTH;
    localparam int WY   = WORLD_CHUNKS_Y * CHUNK_WIDTH;
    localparam int WZ   = CHUNK_HEIGHT;
    localparam int ROWS = WY * WZ;
    localparam int AW   = $clog2(ROWS);
    localparam int XW   = $clog2(WX);
    localparam int MXY  = (WX > WY) ? WX : WY;
    localparam int MXYZ = (MXY > WZ) ? MXY : WZ;
    localparam int MALL = (MXYZ > 128) ? MXYZ : 128;
    localparam int POS_W = $clog2(MALL) + 2;
    localparam int OFF_W = MULP_W - 14;
    localparam int PT_W  = OFF_W + 2;
    localparam logic [AW:0] WY_C = (AW+1)'(WY);
    localparam logic signed [PT_W-1:0] PT_MAX = PT_W'(8388607);
    localparam logic signed [PT_W-1:0] PT_MIN = -PT_W'(8388608);

    // occupancy, one row of x bits per (z, y)
    logic [WX-1:0] r_mem [ROWS];

    t_state r_state, n_state;
    t_dop   r_dop;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_k;
    logic          r_march;
    logic          r_hit;
    logic [1:0]    r_axis;
    logic [2:0]    r_side;

    logic signed [ORG_W-1:0] r_org [3];
    logic signed [DIR_W-1:0] r_dir [3];
    logic signed [POS_W-1:0] r_pos [3];
    logic [FRAC_W-1:0]       r_frac [3];
    logic [T_W-1:0]          r_delta [3];
    logic [T_W-1:0]          r_t [3];
    logic signed [ORG_W-1:0] r_pt [3];
    logic [DIST_W-1:0]       r_maxd;
    logic [T_W-1:0]          r_tmax;
    logic [T_W-1:0]          r_tent;
    logic [31:0]             r_sqv, r_sqr, r_sqb;
    logic [MULP_W-1:0]       r_prod;

    logic [WX-1:0] r_rd_row;
    logic          r_rd_inw;
    logic [XW-1:0] r_rd_x;

    logic                    r_o_valid, r_o_hit;
    logic [1:0]              r_o_chx, r_o_chy;
    logic [3:0]              r_o_blx, r_o_bly;
    logic [5:0]              r_o_blz;
    logic signed [ORG_W-1:0] r_o_px, r_o_py, r_o_pz;
    logic [2:0]              r_o_side;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic signed [ORG_W-1:0] org_in [3];
    logic signed [DIR_W-1:0] dir_in [3];
    logic [DIR_W-1:0]        ad [3];
    logic signed [POS_W-1:0] lim [3];
    logic [MULA_W-1:0]       mul_a;
    logic [T_W-1:0]          mul_b;

    logic          accept, acc_cast, acc_write;
    logic          w_inw;
    logic [AW-1:0] w_addr;
    logic          rd_inw;
    logic [AW-1:0] rd_addr;
    logic          solid, dir_zero, last_k, out_free;
    logic          exit_any, step_stop;
    logic [1:0]    axis;
    logic [T_W-1:0] tent, sel_delta, t_next;
    logic [31:0]   sq_bsum;
    logic          sq_ge;
    logic [OFF_W-1:0]      off;
    logic signed [PT_W-1:0] pt_sum;
    logic [2:0]    hit_side;
    logic [POS_W-1:0] px, py, bx, by;
    logic [1:0]    chx, chy;

    vrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        org_in[0] = i_origin_x;
        org_in[1] = i_origin_y;
        org_in[2] = i_origin_z;
        dir_in[0] = i_dir_x;
        dir_in[1] = i_dir_y;
        dir_in[2] = i_dir_z;
        lim[0] = POS_W'(WX);
        lim[1] = POS_W'(WY);
        lim[2] = POS_W'(WZ);
        for (int k = 0; k < 3; k++) begin
            ad[k] = r_dir[k][DIR_W-1] ? DIR_W'(-r_dir[k]) : DIR_W'(r_dir[k]);
        end
    end

    assign accept    = i_valid && o_ready;
    assign acc_cast  = accept && (i_cmd == CMD_CAST);
    assign acc_write = accept && (i_cmd == CMD_WRITE);
    assign last_k    = (r_k == 2'd2);
    assign out_free  = !r_o_valid || i_ready;
    assign dir_zero  = (r_dir[0] == '0) && (r_dir[1] == '0) && (r_dir[2] == '0);
    assign solid     = r_rd_inw && r_rd_row[r_rd_x];

    // write address
    always_comb begin
        w_inw  = (int'(i_voxel_x) < WX) && (int'(i_voxel_y) < WY) &&
                 (int'(i_voxel_z) < WZ);
        w_addr = AW'((AW+1)'(i_voxel_z) * WY_C + (AW+1)'(i_voxel_y));
    end

    // read address from the current voxel
    always_comb begin
        rd_inw = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (r_pos[k] < 0 || r_pos[k] >= lim[k]) rd_inw = 1'b0;
        end
        rd_addr = AW'((AW+1)'($unsigned(r_pos[2])) * WY_C + (AW+1)'($unsigned(r_pos[1])));
        if (!rd_inw) rd_addr = '0;
    end

    // chunk and local block of the current voxel by compare and subtract
    always_comb begin
        px  = $unsigned(r_pos[0]);
        py  = $unsigned(r_pos[1]);
        chx = 2'd0;
        chy = 2'd0;
        bx  = px;
        by  = py;
        for (int c = 1; c < WORLD_CHUNKS_X; c++) begin
            if (px >= POS_W'(c * CHUNK_LENGTH)) begin
                chx = 2'(c);
                bx  = px - POS_W'(c * CHUNK_LENGTH);
            end
        end
        for (int c = 1; c < WORLD_CHUNKS_Y; c++) begin
            if (py >= POS_W'(c * CHUNK_WIDTH)) begin
                chy = 2'(c);
                by  = py - POS_W'(c * CHUNK_WIDTH);
            end
        end
    end

    // march step: axis choice, stop test, next crossing
    always_comb begin
        exit_any = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if ((r_pos[k] < 0 && r_dir[k] <= 0) || (r_pos[k] >= lim[k] && r_dir[k] >= 0))
                exit_any = 1'b1;
        end
        if (r_t[0] < r_t[1] && r_t[0] < r_t[2]) axis = 2'd0;
        else if (r_t[1] < r_t[2])               axis = 2'd1;
        else                                    axis = 2'd2;
        case (axis)
            2'd0:    begin tent = r_t[0]; sel_delta = r_delta[0]; end
            2'd1:    begin tent = r_t[1]; sel_delta = r_delta[1]; end
            default: begin tent = r_t[2]; sel_delta = r_delta[2]; end
        endcase
        step_stop = exit_any || (tent >= r_tmax);
        t_next = ((T_SAT - tent) < sel_delta) ? T_SAT : tent + sel_delta;
    end

    // square root digit
    always_comb begin
        sq_bsum = r_sqr + r_sqb;
        sq_ge   = (r_sqv >= sq_bsum);
    end

    // hit point for axis r_k from the registered product
    always_comb begin
        off = r_prod[MULP_W-1:14];
        if (r_dir[r_k][DIR_W-1]) pt_sum = PT_W'(r_org[r_k]) - $signed({2'b00, off});
        else                     pt_sum = PT_W'(r_org[r_k]) + $signed({2'b00, off});
    end

    always_comb begin
        case (r_axis)
            2'd0:    hit_side = (r_dir[0] > 0) ? SIDE_BACK : SIDE_FRONT;
            2'd1:    hit_side = (r_dir[1] > 0) ? SIDE_LEFT : SIDE_RIGHT;
            default: hit_side = (r_dir[2] > 0) ? SIDE_BOTTOM : SIDE_TOP;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(ROWS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (acc_cast) n_state = ST_RD;
            ST_RD:    n_state = ST_CHK;
            ST_CHK: begin
                if (r_march) n_state = solid ? ST_PT_M : ST_STEP;
                else if (solid) n_state = ST_FIN;
                else if (dir_zero) n_state = ST_FIN;
                else n_state = ST_SQ_M;
            end
            ST_SQ_M:  n_state = ST_SQ_A;
            ST_SQ_A:  n_state = last_k ? ST_SQRT : ST_SQ_M;
            ST_SQRT:  if (r_sqb[0]) n_state = ST_DIV_S;
            ST_DIV_S: n_state = ST_DIV_W;
            ST_DIV_W: begin
                if (div_rsp.done) begin
                    unique case (r_dop)
                        DOP_TMAX:  n_state = ST_DSEL;
                        DOP_DELTA: n_state = last_k ? ST_TI_M : ST_DSEL;
                        default:   n_state = ST_FIN;
                    endcase
                end
            end
            ST_DSEL: begin
                if (r_dir[r_k] != '0) n_state = ST_DIV_S;
                else if (last_k)      n_state = ST_TI_M;
            end
            ST_TI_M:  n_state = ST_TI_A;
            ST_TI_A:  n_state = last_k ? ST_STEP : ST_TI_M;
            ST_STEP:  n_state = step_stop ? ST_FIN : ST_RD;
            ST_PT_M:  n_state = ST_PT_A;
            ST_PT_A:  n_state = last_k ? ST_FIN : ST_PT_M;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, multiplier operands, divider request
    always_comb begin
        o_ready          = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_SQ_M: begin
                mul_a = MULA_W'(ad[r_k]);
                mul_b = T_W'(ad[r_k]);
            end
            ST_TI_M: begin
                mul_a = (r_dir[r_k] > 0) ? MULA_W'(17'h10000 - {1'b0, r_frac[r_k]})
                                         : MULA_W'(r_frac[r_k]);
                mul_b = r_delta[r_k];
            end
            ST_PT_M: begin
                mul_a = MULA_W'(ad[r_k]);
                mul_b = r_tent;
            end
            ST_DIV_S: begin
                div_req.start = 1'b1;
                unique case (r_dop)
                    DOP_TMAX: begin
                        div_req.dividend = DIVN_W'({r_maxd, 14'b0});
                        div_req.divisor  = r_sqr[DIVD_W-1:0];
                    end
                    DOP_DELTA: begin
                        div_req.dividend = DIVN_W'(64'd1 << 30);
                        div_req.divisor  = DIVD_W'(ad[r_k]);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

    // memory: clearing sweep, voxel writes, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem[r_clr] <= '0;
        end else if (acc_write && w_inw) begin
            r_mem[w_addr][XW'(i_voxel_x)] <= (i_voxel_value != '0);
        end
        r_rd_row <= r_mem[rd_addr];
        r_rd_inw <= rd_inw;
        r_rd_x   <= XW'($unsigned(r_pos[0]));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MULP_W'(mul_a * mul_b);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (acc_cast) begin
                    for (int k = 0; k < 3; k++) begin
                        r_org[k]  <= org_in[k];
                        r_dir[k]  <= dir_in[k];
                        r_pos[k]  <= POS_W'($signed(org_in[k][ORG_W-1:FRAC_W]));
                        r_frac[k] <= org_in[k][FRAC_W-1:0];
                    end
                    r_maxd  <= i_max_distance;
                    r_march <= 1'b0;
                    r_hit   <= 1'b0;
                end
            end
            ST_CHK: begin
                r_k <= 2'd0;
                if (solid) begin
                    r_hit  <= 1'b1;
                    if (r_march) begin
                        r_side <= hit_side;
                    end else begin
                        r_side <= SIDE_UNKNOWN;
                        for (int k = 0; k < 3; k++) r_pt[k] <= r_org[k];
                    end
                end else if (!r_march) begin
                    r_sqv <= '0;
                end
            end
            ST_SQ_A: begin
                r_k <= r_k + 1'b1;
                if (last_k) begin
                    r_sqv <= r_sqv + r_prod[31:0];
                    r_sqr <= '0;
                    r_sqb <= 32'h4000_0000;
                    r_dop <= DOP_TMAX;
                end else begin
                    r_sqv <= r_sqv + r_prod[31:0];
                end
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    r_sqv <= r_sqv - sq_bsum;
                    r_sqr <= (r_sqr >> 1) + r_sqb;
                end else begin
                    r_sqr <= r_sqr >> 1;
                end
                r_sqb <= r_sqb >> 2;
            end
            ST_DIV_W: begin
                if (div_rsp.done) begin
                    unique case (r_dop)
                        DOP_TMAX: begin
                            r_tmax <= div_rsp.quot;
                            r_k    <= 2'd0;
                        end
                        DOP_DELTA: begin
                            r_delta[r_k] <= div_rsp.quot;
                            r_k          <= last_k ? 2'd0 : r_k + 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DSEL: begin
                if (r_dir[r_k] != '0) begin
                    r_dop <= DOP_DELTA;
                end else begin
                    r_delta[r_k] <= T_SAT;
                    r_t[r_k]     <= T_SAT;
                    r_k          <= last_k ? 2'd0 : r_k + 1'b1;
                end
            end
            ST_TI_A: begin
                if (r_dir[r_k] != '0) r_t[r_k] <= T_W'(r_prod >> 16);
                r_k <= last_k ? 2'd0 : r_k + 1'b1;
                if (last_k) r_march <= 1'b1;
            end
            ST_STEP: begin
                if (!step_stop) begin
                    r_tent <= tent;
                    r_axis <= axis;
                    for (int k = 0; k < 3; k++) begin
                        if (axis == 2'(k)) begin
                            r_pos[k] <= r_dir[k][DIR_W-1] ? r_pos[k] - 1'b1
                                                          : r_pos[k] + 1'b1;
                            r_t[k]   <= t_next;
                        end
                    end
                end
            end
            ST_PT_A: begin
                if (pt_sum > PT_MAX)      r_pt[r_k] <= PT_MAX[ORG_W-1:0];
                else if (pt_sum < PT_MIN) r_pt[r_k] <= PT_MIN[ORG_W-1:0];
                else                      r_pt[r_k] <= pt_sum[ORG_W-1:0];
                r_k <= last_k ? 2'd0 : r_k + 1'b1;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_o_hit  <= r_hit;
            r_o_chx  <= r_hit ? chx : 2'd0;
            r_o_chy  <= r_hit ? chy : 2'd0;
            r_o_blx  <= r_hit ? bx[3:0] : 4'd0;
            r_o_bly  <= r_hit ? by[3:0] : 4'd0;
            r_o_blz  <= r_hit ? 6'($unsigned(r_pos[2])) : 6'd0;
            r_o_px   <= r_hit ? r_pt[0] : '0;
            r_o_py   <= r_hit ? r_pt[1] : '0;
            r_o_pz   <= r_hit ? r_pt[2] : '0;
            r_o_side <= r_hit ? r_side : SIDE_UNKNOWN;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_hit     = r_o_hit;
    assign o_chunk_x = r_o_chx;
    assign o_chunk_y = r_o_chy;
    assign o_block_x = r_o_blx;
    assign o_block_y = r_o_bly;
    assign o_block_z = r_o_blz;
    assign o_point_x = r_o_px;
    assign o_point_y = r_o_py;
    assign o_point_z = r_o_pz;
    assign o_side    = r_o_side;

endmodule

[hw/rtl/vrt_div.sv]
module vrt_div import vrt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVN_W-1:0] r_num;
    logic [DIVD_W-1:0] r_den;
    logic [DIVD_W-1:0] r_rem;

    logic [DIVD_W:0] rem_sh;
    logic            q_bit;

    // restoring division, one quotient bit a cycle
    always_comb begin
        rem_sh = {r_rem, r_num[DIVN_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIVN_W-2:0], q_bit};
            if (q_bit) begin
                r_rem <= DIVD_W'(rem_sh - {1'b0, r_den});
            end else begin
                r_rem <= rem_sh[DIVD_W-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

[hw/rtl/vrt_chk.sv]
`include "voxel_ray_traversal_macros.svh"

module vrt_chk import vrt_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic                    i_cmd,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic                    o_hit,
    input logic [1:0]              o_chunk_x,
    input logic signed [ORG_W-1:0] o_point_x,
    input logic [2:0]              o_side
);

    // a stalled result stays offered
    `VRT_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped while stalled")

    // reset starts the clearing sweep with nothing offered
    `VRT_AST_NEXT_ALWAYS(a_reset_busy, i_clk, !i_rst_n, !o_ready && !o_valid, "not busy after reset")

    // a cast request keeps the block busy
    `VRT_AST_NEXT(a_cast_busy, i_clk, i_rst_n, i_valid && o_ready && (i_cmd == CMD_CAST), !o_ready, "ready during cast")

    // a miss carries zero side, point x and chunk x fields
    `VRT_AST_SAME(a_miss_zero, i_clk, i_rst_n, o_valid && !o_hit, (o_side == SIDE_UNKNOWN) && (o_point_x == '0) && (o_chunk_x == '0), "miss with nonzero fields")

endmodule

bind voxel_ray_traversal vrt_chk u_vrt_chk (.*);

[test/voxel_ray_traversal_tb.sv]
`timescale 1ns / 100ps

import vrt_pkg::*;

typedef struct packed {
    logic                     cmd;
    logic [VOX_W-1:0]         vx;
    logic [VOX_W-1:0]         vy;
    logic [VOX_W-1:0]         vz;
    logic [VAL_W-1:0]         value;
    logic signed [ORG_W-1:0]  ox;
    logic signed [ORG_W-1:0]  oy;
    logic signed [ORG_W-1:0]  oz;
    logic signed [DIR_W-1:0]  dx;
    logic signed [DIR_W-1:0]  dy;
    logic signed [DIR_W-1:0]  dz;
    logic [DIST_W-1:0]        reach;
} t_vox_req;

typedef struct packed {
    logic                     hit;
    logic [1:0]               chunk_x;
    logic [1:0]               chunk_y;
    logic [3:0]               block_x;
    logic [3:0]               block_y;
    logic [5:0]               block_z;
    logic signed [ORG_W-1:0]  point_x;
    logic signed [ORG_W-1:0]  point_y;
    logic signed [ORG_W-1:0]  point_z;
    logic [2:0]               side;
} t_ray_res;

class vox_scoreboard;
    localparam longint unsigned STEP_SAT = (64'd1 << 40) - 1;
    localparam int WORLD_EDGE = 64;

    bit       occ [262144];
    t_ray_res hits_due [$];
    int       mismatches;

    function bit solid_at(longint p0, longint p1, longint p2);
        if (p0 < 0 || p0 >= WORLD_EDGE || p1 < 0 || p1 >= WORLD_EDGE ||
            p2 < 0 || p2 >= WORLD_EDGE) begin
            return 1'b0;
        end
        return occ[p2 * 4096 + p1 * 64 + p0];
    endfunction

    function t_ray_res cast_ray(t_vox_req r);
        longint          org [3];
        longint          dir [3];
        longint          pos [3];
        longint          pt [3];
        longint unsigned frac [3];
        longint unsigned delta [3];
        longint unsigned tc [3];
        int              stp [3];
        longint unsigned sum, norm, tmax, tent, ad, off, u, sq;
        longint          p;
        int              ax;
        t_ray_res        res;
        res = '0;
        org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
        dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            u = longint'(org[k] + 64'sh800000);
            pos[k] = longint'(u >> 16) - 128;
            frac[k] = u & 64'hFFFF;
            sum += longint'(dir[k] * dir[k]);
        end
        if (solid_at(pos[0], pos[1], pos[2])) begin
            res.hit = 1'b1;
            res.chunk_x = pos[0][5:4];  res.block_x = pos[0][3:0];
            res.chunk_y = pos[1][5:4];  res.block_y = pos[1][3:0];
            res.block_z = pos[2][5:0];
            res.point_x = r.ox; res.point_y = r.oy; res.point_z = r.oz;
            res.side = SIDE_UNKNOWN;
            return res;
        end
        if (sum == 0) return res;
        norm = 0;
        for (int b = 17; b >= 0; b--) begin
            sq = (norm | (64'd1 << b)) * (norm | (64'd1 << b));
            if (sq <= sum) norm |= (64'd1 << b);
        end
        tmax = (longint'(r.reach) << 14) / norm;
        for (int k = 0; k < 3; k++) begin
            if (dir[k] == 0) begin
                stp[k] = 0; delta[k] = STEP_SAT; tc[k] = STEP_SAT;
            end else begin
                ad = dir[k] < 0 ? -dir[k] : dir[k];
                delta[k] = (64'd1 << 30) / ad;
                stp[k] = dir[k] > 0 ? 1 : -1;
                tc[k] = dir[k] > 0 ? ((65536 - frac[k]) * delta[k]) >> 16
                                   : (frac[k] * delta[k]) >> 16;
            end
        end
        forever begin
            // outside the world and not heading back in: nothing to find
            for (int k = 0; k < 3; k++) begin
                if ((pos[k] < 0 && stp[k] <= 0) || (pos[k] >= WORLD_EDGE && stp[k] >= 0))
                    return res;
            end
            if (tc[0] < tc[1] && tc[0] < tc[2]) ax = 0;
            else if (tc[1] < tc[2]) ax = 1;
            else ax = 2;
            tent = tc[ax];
            if (tent >= tmax) return res;
            pos[ax] += stp[ax];
            tc[ax] = (STEP_SAT - tent < delta[ax]) ? STEP_SAT : tent + delta[ax];
            if (solid_at(pos[0], pos[1], pos[2])) begin
                for (int k = 0; k < 3; k++) begin
                    ad = dir[k] < 0 ? -dir[k] : dir[k];
                    off = (ad * tent) >> 14;
                    p = dir[k] < 0 ? org[k] - longint'(off) : org[k] + longint'(off);
                    if (p > 8388607) p = 8388607;
                    if (p < -8388608) p = -8388608;
                    pt[k] = p;
                end
                res.hit = 1'b1;
                res.chunk_x = pos[0][5:4];  res.block_x = pos[0][3:0];
                res.chunk_y = pos[1][5:4];  res.block_y = pos[1][3:0];
                res.block_z = pos[2][5:0];
                res.point_x = pt[0][23:0]; res.point_y = pt[1][23:0];
                res.point_z = pt[2][23:0];
                case (ax)
                    0: res.side = stp[0] > 0 ? SIDE_BACK : SIDE_FRONT;
                    1: res.side = stp[1] > 0 ? SIDE_LEFT : SIDE_RIGHT;
                    default: res.side = stp[2] > 0 ? SIDE_BOTTOM : SIDE_TOP;
                endcase
                return res;
            end
        end
    endfunction

    function void note_request(t_vox_req r);
        if (r.cmd == CMD_WRITE) begin
            occ[{r.vz, r.vy, r.vx}] = (r.value != 0);
        end else begin
            hits_due.push_back(cast_ray(r));
        end
    endfunction

    function void check_result(t_ray_res got);
        t_ray_res want;
        if (hits_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        want = hits_due.pop_front();
        if (got.hit !== want.hit || got.chunk_x !== want.chunk_x ||
            got.chunk_y !== want.chunk_y || got.block_x !== want.block_x ||
            got.block_y !== want.block_y || got.block_z !== want.block_z ||
            got.point_x !== want.point_x || got.point_y !== want.point_y ||
            got.point_z !== want.point_z || got.side !== want.side) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
        end
    endfunction
endclass

module voxel_ray_traversal_tb;
    localparam int REQ_W = $bits(t_vox_req);

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_cmd;
    logic [VOX_W-1:0]        i_voxel_x, i_voxel_y, i_voxel_z;
    logic [VAL_W-1:0]        i_voxel_value;
    logic signed [ORG_W-1:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [DIR_W-1:0] i_dir_x, i_dir_y, i_dir_z;
    logic [DIST_W-1:0]       i_max_distance;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_hit;
    logic [1:0]              o_chunk_x, o_chunk_y;
    logic [3:0]              o_block_x, o_block_y;
    logic [5:0]              o_block_z;
    logic signed [ORG_W-1:0] o_point_x, o_point_y, o_point_z;
    logic [2:0]              o_side;

    vox_scoreboard  sb = new();
    int             hold_left;
    bit             no_idle;
    logic [17:0]    solids [$];

    voxel_ray_traversal u_dut (.*);

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    initial begin
        #200ms;
        $display("voxel_ray_traversal test failed");
        $finish;
    end

    // result side: random back-pressure, plus a long hold-off on request
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                sb.check_result({o_hit, o_chunk_x, o_chunk_y, o_block_x, o_block_y,
                                 o_block_z, o_point_x, o_point_y, o_point_z, o_side});
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (no_idle) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 35);
            end
        end
    end

    task automatic send(t_vox_req r);
        i_valid        <= 1'b1;
        i_cmd          <= r.cmd;
        i_voxel_x      <= r.vx;  i_voxel_y  <= r.vy;  i_voxel_z <= r.vz;
        i_voxel_value  <= r.value;
        i_origin_x     <= r.ox;  i_origin_y <= r.oy;  i_origin_z <= r.oz;
        i_dir_x        <= r.dx;  i_dir_y    <= r.dy;  i_dir_z   <= r.dz;
        i_max_distance <= r.reach;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(r);
        if (!no_idle && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic put_voxel(int x, int y, int z, int v);
        t_vox_req r;
        r = '0;
        r.cmd = CMD_WRITE;
        r.vx = VOX_W'(x); r.vy = VOX_W'(y); r.vz = VOX_W'(z); r.value = VAL_W'(v);
        if (v != 0) solids.push_back({r.vz, r.vy, r.vx});
        send(r);
    endtask

    // origin Q8.16, direction Q2.14
    task automatic cast(int ox, int oy, int oz, int dx, int dy, int dz, int reach);
        t_vox_req r;
        r = '0;
        r.cmd = CMD_CAST;
        r.ox = ORG_W'(ox); r.oy = ORG_W'(oy); r.oz = ORG_W'(oz);
        r.dx = DIR_W'(dx); r.dy = DIR_W'(dy); r.dz = DIR_W'(dz);
        r.reach = DIST_W'(reach);
        send(r);
    endtask

    task automatic aimed_cast();
        t_vox_req    r;
        logic [17:0] tgt;
        longint      tv [3];
        longint      ov [3];
        longint      dv [3];
        longint      m, scale;
        r = '0;
        r.cmd = CMD_CAST;
        tgt = solids[$urandom_range(solids.size() - 1)];
        tv[0] = (longint'(tgt[5:0]) << 16) + 32768;
        tv[1] = (longint'(tgt[11:6]) << 16) + 32768;
        tv[2] = (longint'(tgt[17:12]) << 16) + 32768;
        m = 1;
        for (int k = 0; k < 3; k++) begin
            ov[k] = tv[k] + longint'($urandom_range(1048576)) - 524288;
            dv[k] = tv[k] - ov[k];
            if ($urandom_range(99) < 12) dv[k] = 0;
            if (dv[k] > m) m = dv[k];
            if (-dv[k] > m) m = -dv[k];
        end
        scale = $urandom_range(4096, 32767);
        r.ox = ORG_W'(ov[0]); r.oy = ORG_W'(ov[1]); r.oz = ORG_W'(ov[2]);
        r.dx = DIR_W'(dv[0] * scale / m);
        r.dy = DIR_W'(dv[1] * scale / m);
        r.dz = DIR_W'(dv[2] * scale / m);
        r.reach = $urandom_range(99) < 90 ? DIST_W'($urandom_range(1 << 20))
                                          : DIST_W'($urandom);
        send(r);
    endtask

    initial begin
        t_vox_req r;
        int       pick;
        hold_left = 0;
        no_idle = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cmd <= CMD_WRITE;
        i_voxel_x <= '0; i_voxel_y <= '0; i_voxel_z <= '0; i_voxel_value <= '0;
        i_origin_x <= '0; i_origin_y <= '0; i_origin_z <= '0;
        i_dir_x <= '0; i_dir_y <= '0; i_dir_z <= '0; i_max_distance <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_voxel(0, 0, 0, 1);
        put_voxel(63, 63, 63, 255);
        put_voxel(10, 10, 10, 128);
        put_voxel(20, 20, 20, 7);
        put_voxel(20, 20, 20, 0);                              // cleared again
        cast(32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 0);        // solid start voxel
        cast(32'h3F8000, 32'h3F8000, 32'h3F8000, 16384, 0, 0, 24'hFFFFFF);
        cast(32'h58000, 32'h58000, 32'h58000, 0, 0, 0, 24'hFFFFFF); // zero direction
        cast(32'hA8000, 32'hA8000, 32'h58000, 0, 0, 16384, 24'h0A0000);   // bottom face
        cast(32'hA8000, 32'hA8000, 32'h108000, 0, 0, -16384, 24'h0A0000); // top face
        cast(32'h58000, 32'hA8000, 32'hA8000, 16384, 0, 0, 24'h0A0000);   // back face
        cast(32'h108000, 32'hA8000, 32'hA8000, -16384, 0, 0, 24'h0A0000); // front face
        cast(32'hA8000, 32'h58000, 32'hA8000, 0, 16384, 0, 24'h0A0000);   // left face
        cast(32'hA8000, 32'h108000, 32'hA8000, 0, -16384, 0, 24'h0A0000); // right face
        cast(32'hA8000, 32'h58000, 32'hA8000, 0, 16384, 0, 0);            // no reach
        cast(32'h58000, 32'h58000, 32'h58000, 32767, 32767, 32767, 24'hFFFFFF);
        cast(-32'h10000, 32'h8000, 32'h8000, -32768, 0, 0, 24'hFFFFFF);   // receding
        cast(-32'sd8388608, -32'sd8388608, -32'sd8388608, 32767, 32767, 32767,
             24'hFFFFFF);
        cast(32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, -32768, -32768, -32768, 24'hFFFFFF);
        cast(32'h48000, 32'hA8000, 32'hA8000, 16384, 1, 0, 24'h0A0000);

        for (int n = 0; n < 1450; n++) begin
            no_idle = (n >= 300 && n < 480);
            if (n == 700) hold_left = 3000;
            if (n == 900) begin
                i_valid <= 1'b0;
                while (sb.hits_due.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                if ($urandom_range(99) < 80) begin
                    put_voxel($urandom_range(16, 47), $urandom_range(16, 47),
                              $urandom_range(16, 47),
                              $urandom_range(99) < 85 ? $urandom_range(1, 255) : 0);
                end else begin
                    put_voxel($urandom_range(63), $urandom_range(63), $urandom_range(63),
                              $urandom_range(255));
                end
            end else if (pick < 90) begin
                aimed_cast();
            end else begin
                r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                r.cmd = CMD_CAST;
                send(r);
            end
        end

        i_valid <= 1'b0;
        while (sb.hits_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("voxel_ray_traversal test passed");
        end else begin
            $display("voxel_ray_traversal test failed");
        end
        $finish;
    end
endmodule
